>>> rtl/core/ipv_pkg.sv
`default_nettype none

package ipv_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_COLON = 8'h3a;

  localparam logic [8:0] V4_GROUP_MAX  = 9'd255;
  localparam logic [8:0] V4_GROUP_SAT  = 9'd256;
  localparam logic [2:0] V4_DIGITS_MAX = 3'd3;
  localparam logic [2:0] V6_DIGITS_MAX = 3'd4;
  localparam logic [2:0] DIGITS_SAT    = 3'd7;
  localparam logic [3:0] SEP_SAT       = 4'd15;
  localparam logic [3:0] V4_SEPS       = 4'd3;
  localparam logic [3:0] V6_SEPS       = 4'd7;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_V4   = 2'd1,
    CLS_V6   = 2'd2
  } addr_class_t;

  typedef struct packed {
    logic       is_dec;
    logic       is_hex_letter;
    logic       is_dot;
    logic       is_colon;
    logic [3:0] digit;
  } char_class_t;

endpackage

`default_nettype wire

>>> rtl/core/ipv_classify.sv
`default_nettype none

module ipv_classify (
  input  wire logic [7:0]          char_code,
  output ipv_pkg::char_class_t     cc
);
  import ipv_pkg::*;

  logic [7:0] dec_off;

  assign dec_off = char_code - CHAR_ZERO;

  always_comb begin
    cc = '0;
    cc.digit = dec_off[3:0];
    if (char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
      cc.is_dec = 1'b1;
    end else if (char_code inside {[CHAR_LO_A:CHAR_LO_F], [CHAR_UP_A:CHAR_UP_F]}) begin
      cc.is_hex_letter = 1'b1;
    end else if (char_code == CHAR_DOT) begin
      cc.is_dot = 1'b1;
    end else if (char_code == CHAR_COLON) begin
      cc.is_colon = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ipv_track.sv
`default_nettype none

module ipv_track (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic                last,
  input  wire ipv_pkg::char_class_t cc,
  output ipv_pkg::addr_class_t     cls
);
  import ipv_pkg::*;

  logic       v4_r, v4_nxt;
  logic       v6_r, v6_nxt;
  logic [3:0] sep_r, sep_nxt;
  logic [2:0] dig_r, dig_nxt;
  logic [8:0] val_r, val_nxt;
  logic       sz_r, sz_nxt;

  logic [11:0] prod;
  logic        fin_v4;
  logic        fin_v6;

  assign prod = {val_r, 3'b000} + {2'b00, val_r, 1'b0} + {8'd0, cc.digit};

  always_comb begin
    v4_nxt  = v4_r;
    v6_nxt  = v6_r;
    sep_nxt = sep_r;
    dig_nxt = dig_r;
    val_nxt = val_r;
    sz_nxt  = sz_r;
    if (cc.is_dec || cc.is_hex_letter) begin
      if (dig_r == 3'd0) begin
        sz_nxt = cc.is_dec && (cc.digit == 4'd0);
      end else if (sz_r) begin
        v4_nxt = 1'b0;
      end
      if (dig_r < DIGITS_SAT) begin
        dig_nxt = dig_r + 3'd1;
      end
      if (cc.is_dec) begin
        val_nxt = (prod > {3'd0, V4_GROUP_SAT}) ? V4_GROUP_SAT : prod[8:0];
      end else begin
        v4_nxt = 1'b0;
      end
      if (dig_nxt > V4_DIGITS_MAX || val_nxt > V4_GROUP_MAX) begin
        v4_nxt = 1'b0;
      end
      if (dig_nxt > V6_DIGITS_MAX) begin
        v6_nxt = 1'b0;
      end
    end else if (cc.is_dot || cc.is_colon) begin
      if (cc.is_dot) begin
        v6_nxt = 1'b0;
      end else begin
        v4_nxt = 1'b0;
      end
      if (dig_r == 3'd0) begin
        v4_nxt = 1'b0;
        v6_nxt = 1'b0;
      end
      if (sep_r < SEP_SAT) begin
        sep_nxt = sep_r + 4'd1;
      end
      dig_nxt = 3'd0;
      val_nxt = 9'd0;
      sz_nxt  = 1'b0;
    end else begin
      v4_nxt = 1'b0;
      v6_nxt = 1'b0;
    end
  end

  // final group must be nonempty
  assign fin_v4 = v4_nxt && (dig_nxt != 3'd0) && (sep_nxt == V4_SEPS);
  assign fin_v6 = v6_nxt && (dig_nxt != 3'd0) && (sep_nxt == V6_SEPS);

  always_comb begin
    if (fin_v4) begin
      cls = CLS_V4;
    end else if (fin_v6) begin
      cls = CLS_V6;
    end else begin
      cls = CLS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r  <= 1'b1;
      v6_r  <= 1'b1;
      sep_r <= 4'd0;
      dig_r <= 3'd0;
      val_r <= 9'd0;
      sz_r  <= 1'b0;
    end else if (step) begin
      if (last) begin
        v4_r  <= 1'b1;
        v6_r  <= 1'b1;
        sep_r <= 4'd0;
        dig_r <= 3'd0;
        val_r <= 9'd0;
        sz_r  <= 1'b0;
      end else begin
        v4_r  <= v4_nxt;
        v6_r  <= v6_nxt;
        sep_r <= sep_nxt;
        dig_r <= dig_nxt;
        val_r <= val_nxt;
        sz_r  <= sz_nxt;
      end
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> v4_r && v6_r && sep_r == 4'd0 && dig_r == 3'd0)
    else $error("state not restored after final character");

  a_empty_group: assert property (@(posedge clk) disable iff (!rst_n)
    dig_r == 3'd0 |-> val_r == 9'd0 && !sz_r)
    else $error("empty group carries value or zero flag");

  a_val_sat: assert property (@(posedge clk) disable iff (!rst_n)
    val_r <= V4_GROUP_SAT)
    else $error("group value beyond saturation");

endmodule

`default_nettype wire

>>> rtl/core/ip_address_text_validator.sv
`default_nettype none
// IPv4 / IPv6 address text validator.
// Input channel: in_char_code carries one character per transfer; in_last_char
// marks the final character of the string. Output channel: out_address_class
// gives one result per string (0 neither, 1 IPv4, 2 IPv6), only for the
// transfer that carried in_last_char.
// A character enters an input register on its transfer; from that register it
// updates the scan state and, if final, loads the result register behind out_valid.
// Throughput: one character per cycle while no held result stalls a final
// character; the scan state update is classify/compare/add logic between the
// input and state registers.
// Reset (rst_n low, synchronous) empties both registers and returns the scan
// to the start of a string. After a final character the scan restarts by
// itself. When the receiver stalls, the result is held in the output register
// and characters keep flowing until a second final character reaches the
// input register; that one waits there and in_ready drops until the held
// result is taken.
module ip_address_text_validator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_last_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_address_class
);
  import ipv_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;
  logic        out_valid_r;
  addr_class_t out_cls_r;

  logic        advance;
  char_class_t cc;
  addr_class_t cls;

  assign advance  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  ipv_classify u_classify (
    .char_code (s1_char_r),
    .cc        (cc)
  );

  ipv_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .last  (s1_last_r),
    .cc    (cc),
    .cls   (cls)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_cls_r <= cls;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_address_class = out_cls_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("held result would be overwritten");

endmodule

`default_nettype wire

>>> test/ip_address_text_validator_tb.sv
module ip_address_text_validator_tb;
  import ipv_pkg::*;

  localparam int IDLE_LIMIT    = 3000;
  localparam int RANDOM_CHARS  = 1250;
  localparam int HOLD_AT       = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_AT      = 30;
  localparam int BURST_FIRST   = 45;
  localparam int BURST_LAST    = 60;

  class addr_scoreboard;
    bit            can_be_v4;
    bit            can_be_v6;
    logic [3:0]    sep_count;
    logic [2:0]    group_len;
    logic [8:0]    group_val;
    bit            lead_zero;
    addr_class_t   class_q[$];
    int            errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      can_be_v4 = 1'b1;
      can_be_v6 = 1'b1;
      sep_count = '0;
      group_len = '0;
      group_val = '0;
      lead_zero = 1'b0;
    endfunction

    function void close_group();
      if (group_len == 0) begin
        can_be_v4 = 1'b0;
        can_be_v6 = 1'b0;
      end
      if (sep_count != SEP_SAT) sep_count++;
      group_len = '0;
      group_val = '0;
      lead_zero = 1'b0;
    endfunction

    // one accepted input transfer
    function void note_char(logic [7:0] c, logic last);
      bit          is_dec;
      bit          is_hex;
      int unsigned v;
      is_dec = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      is_hex = ((c >= CHAR_LO_A) && (c <= CHAR_LO_F)) ||
               ((c >= CHAR_UP_A) && (c <= CHAR_UP_F));
      if (is_dec || is_hex) begin
        if (group_len == 0) lead_zero = (c == CHAR_ZERO);
        else if (lead_zero) can_be_v4 = 1'b0;
        if (group_len != DIGITS_SAT) group_len++;
        if (is_dec) begin
          v = 32'(group_val) * 10 + 32'(c - CHAR_ZERO);
          group_val = (v > 32'(V4_GROUP_SAT)) ? V4_GROUP_SAT : v[8:0];
        end else begin
          can_be_v4 = 1'b0;
        end
        if (group_len > V4_DIGITS_MAX || group_val > V4_GROUP_MAX) can_be_v4 = 1'b0;
        if (group_len > V6_DIGITS_MAX) can_be_v6 = 1'b0;
      end else if (c == CHAR_DOT) begin
        can_be_v6 = 1'b0;
        close_group();
      end else if (c == CHAR_COLON) begin
        can_be_v4 = 1'b0;
        close_group();
      end else begin
        can_be_v4 = 1'b0;
        can_be_v6 = 1'b0;
      end
      if (last) begin
        if (group_len == 0) begin
          can_be_v4 = 1'b0;
          can_be_v6 = 1'b0;
        end
        if (can_be_v4 && sep_count == V4_SEPS) class_q.push_back(CLS_V4);
        else if (can_be_v6 && sep_count == V6_SEPS) class_q.push_back(CLS_V6);
        else class_q.push_back(CLS_NONE);
        restart();
      end
    endfunction

    // one accepted output transfer
    function void check_class(logic [1:0] actual);
      addr_class_t want;
      if (class_q.size() == 0) begin
        $error("address_class: no result expected, actual %0d", actual);
        errors++;
      end else begin
        want = class_q.pop_front();
        if (actual !== want) begin
          $error("address_class: expected %0d, actual %0d", want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = '0;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_address_class;

  addr_scoreboard sb = new();
  logic [7:0]     text_q[$];
  bit             no_idle = 1'b0;
  int             idle_cycles = 0;

  ip_address_text_validator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .in_last_char      (in_last_char),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_address_class (out_address_class)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_class(out_address_class);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // text builders
  function automatic logic [7:0] hex_char(int unsigned d);
    if (d < 10) return CHAR_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LO_A) + 8'(d - 10);
  endfunction

  function automatic void load_text(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void push_dec(int unsigned v);
    if (v >= 100) text_q.push_back(CHAR_ZERO + 8'(v / 100));
    if (v >= 10) text_q.push_back(CHAR_ZERO + 8'((v / 10) % 10));
    text_q.push_back(CHAR_ZERO + 8'(v % 10));
  endfunction

  function automatic void make_v4();
    int unsigned r;
    text_q.delete();
    for (int g = 0; g < 4; g++) begin
      if (g > 0) text_q.push_back(CHAR_DOT);
      r = $urandom_range(0, 19);
      case (r)
        0: begin
          text_q.push_back(CHAR_ZERO);
          repeat ($urandom_range(1, 2)) text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        1: push_dec($urandom_range(256, 999));
        2: repeat ($urandom_range(4, 9)) text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        3: push_dec($urandom_range(0, 1) ? 255 : 0);
        4, 5, 6: push_dec($urandom_range(0, 9));
        default: push_dec($urandom_range(0, 255));
      endcase
    end
  endfunction

  function automatic void make_v6();
    int unsigned n;
    text_q.delete();
    for (int g = 0; g < 8; g++) begin
      if (g > 0) text_q.push_back(CHAR_COLON);
      n = ($urandom_range(0, 24) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
      repeat (n) text_q.push_back(hex_char($urandom_range(0, 15)));
    end
  endfunction

  function automatic void mutate();
    int unsigned pos;
    pos = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 5))
      0: text_q[pos] = 8'($urandom_range(0, 255));
      1: text_q[pos] = $urandom_range(0, 1) ? CHAR_DOT : CHAR_COLON;
      2: if (text_q.size() > 1) text_q.delete(pos);
      3: text_q.insert(pos, $urandom_range(0, 1) ? CHAR_DOT : CHAR_COLON);
      4: begin
        text_q.push_back(text_q[0] == CHAR_COLON ? CHAR_DOT : CHAR_COLON);
        text_q.push_back(hex_char($urandom_range(0, 15)));
      end
      default: if (text_q.size() > 1) void'(text_q.pop_back());
    endcase
  endfunction

  function automatic void make_noise();
    text_q.delete();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 3))
        0: text_q.push_back(8'($urandom_range(0, 255)));
        1: text_q.push_back($urandom_range(0, 1) ? CHAR_DOT : CHAR_COLON);
        default: text_q.push_back(hex_char($urandom_range(0, 15)));
      endcase
    end
  endfunction

  function automatic void make_sep_chain();
    logic [7:0] sep;
    text_q.delete();
    sep = $urandom_range(0, 1) ? CHAR_DOT : CHAR_COLON;
    repeat ($urandom_range(14, 20)) begin
      text_q.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
      text_q.push_back(sep);
    end
    text_q.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
  endfunction

  // drivers
  task automatic send_char(logic [7:0] c, logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_char_code = c;
    in_last_char = last;
    do @(posedge clk); while (!in_ready);
    sb.note_char(c, last);
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.class_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int unsigned taken;
    int unsigned gap;
    taken = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    string       directed[$];
    int unsigned sent_chars;
    int unsigned str_idx;
    int unsigned r;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed = '{"0.0.0.0", "255.255.255.255", "256.1.1.1", "01.1.1.1", "1.2.3.4.5",
                 ".1.2.3", "1.2.3.", "1..2.3", "1.2:3.4", "1.2.3.a", "1234.1.1.1",
                 "99999999.1.1.1", "0:0:0:0:0:0:0:0",
                 "ffff:FFFF:abcd:ABCD:0123:4567:89aB:cDeF", "12345:1:2:3:4:5:6:7",
                 "1:2:3:4:5:6:7:", ":1:2:3:4:5:6:7", "1:2:3:4:5:6:7:8:9",
                 "1::2:3:4:5:6:7", "1:2:3:4:5:6:7:g", "g", "7", ":",
                 "1:1:1:1:1:1:1:1:1:1:1:1:1:1:1:1:1:1"};
    foreach (directed[i]) begin
      load_text(directed[i]);
      send_text();
    end
    load_text("1.1.1.1");
    text_q[3] = 8'hff;
    send_text();
    load_text("1.1.1.1");
    text_q[6] = 8'h80;
    send_text();

    sent_chars = 0;
    str_idx    = 0;
    while (sent_chars < RANDOM_CHARS) begin
      r = $urandom_range(0, 99);
      if (r < 40) make_v4();
      else if (r < 75) make_v6();
      else if (r < 85) begin
        if ($urandom_range(0, 1)) make_v4();
        else make_v6();
        repeat ($urandom_range(1, 2)) mutate();
      end else if (r < 93) make_noise();
      else if (r < 97) make_sep_chain();
      else begin
        text_q.delete();
        text_q.push_back(8'($urandom_range(0, 255)));
      end
      if (r < 75 && $urandom_range(0, 5) == 0) mutate();
      no_idle = (str_idx >= BURST_FIRST) && (str_idx <= BURST_LAST);
      if (str_idx == DRAIN_AT) wait_drained();
      send_text();
      sent_chars += text_q.size();
      str_idx++;
    end
    no_idle  = 1'b0;
    in_valid = 1'b0;

    while (sb.class_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.class_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
